@@ rtl/core/pacl_pkg.sv @@
// ----------------------------------------------------------------------------
// pacl_pkg
// Shared types and constants for the packet access control list filter:
// command and result payloads, op codes, result codes and the token that
// walks the rule cell chain.
// ----------------------------------------------------------------------------
package pacl_pkg;

    // default number of rule entries per table
    localparam int RULE_DEPTH_DEF = 64;

    // protocol numbers that make the port rules apply
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // command op codes
    typedef enum logic [2:0] {
        OP_CHECK    = 3'd0,
        OP_ADD_ADDR = 3'd1,
        OP_ADD_PORT = 3'd2,
        OP_DEL_ADDR = 3'd3,
        OP_DEL_PORT = 3'd4
    } t_pacl_op;

    // drop causes
    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_ADDR = 2'd1,
        CAUSE_TCP  = 2'd2,
        CAUSE_UDP  = 2'd3
    } t_pacl_cause;

    // command status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_pacl_status;

    // command payload
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] address;
        logic [7:0]  protocol;
        logic [15:0] port;
    } t_pacl_in;

    // result payload
    typedef struct packed {
        logic       drop;
        logic [1:0] drop_cause;
        logic [1:0] status;
    } t_pacl_out;

    // token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic        valid;
        logic [2:0]  op;
        logic [31:0] addr;
        logic [7:0]  proto;
        logic [15:0] port;
        logic        full;     // add to a full table, cells leave entries alone
        logic [31:0] c_addr;   // address value being pushed down on insert
        logic [15:0] c_port;   // port value being pushed down on insert
        logic        hit_addr; // address match seen (check) or removed (delete)
        logic        hit_port; // port match seen (check) or removed (delete)
    } t_pacl_tok;

endpackage

@@ rtl/core/pacl_cell.sv @@
// ----------------------------------------------------------------------------
// pacl_cell
// One rule cell: holds one address rule and one port rule, compares them
// against the passing token, inserts by pushing its entry to the next cell
// and deletes by taking over the entry of the next cell.
// ----------------------------------------------------------------------------
module pacl_cell
    import pacl_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    parameter int CELL_IDX   = 0,
    localparam int FW        = $clog2(RULE_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_pacl_tok       i_tok,
    input  logic [FW-1:0]   i_addr_fill,
    input  logic [FW-1:0]   i_port_fill,
    input  logic [31:0]     i_nxt_addr,
    input  logic [15:0]     i_nxt_port,
    output t_pacl_tok       o_tok,
    output logic [31:0]     o_addr,
    output logic [15:0]     o_port
);

    logic [31:0] r_addr, n_addr;
    logic [15:0] r_port, n_port;
    t_pacl_tok   r_tok, n_tok;
    logic        w_addr_ok, w_port_ok;
    logic        w_match_a, w_match_p;

    // entry is live only below the fill count
    assign w_addr_ok = FW'(CELL_IDX) < i_addr_fill;
    assign w_port_ok = FW'(CELL_IDX) < i_port_fill;
    assign w_match_a = w_addr_ok && (r_addr == i_tok.addr);
    assign w_match_p = w_port_ok && (r_port == i_tok.port);

    // token processing and entry updates
    always_comb begin
        n_addr = r_addr;
        n_port = r_port;
        n_tok  = i_tok;
        if (i_tok.valid) begin
            unique case (t_pacl_op'(i_tok.op))
                OP_CHECK: begin
                    n_tok.hit_addr = i_tok.hit_addr | w_match_a;
                    n_tok.hit_port = i_tok.hit_port | w_match_p;
                end
                OP_ADD_ADDR: begin
                    if (!i_tok.full) begin
                        n_addr       = i_tok.c_addr;
                        n_tok.c_addr = r_addr;
                    end
                end
                OP_ADD_PORT: begin
                    if (!i_tok.full) begin
                        n_port       = i_tok.c_port;
                        n_tok.c_port = r_port;
                    end
                end
                OP_DEL_ADDR: begin
                    if (i_tok.hit_addr || w_match_a) begin
                        n_addr         = i_nxt_addr;
                        n_tok.hit_addr = 1'b1;
                    end
                end
                OP_DEL_PORT: begin
                    if (i_tok.hit_port || w_match_p) begin
                        n_port         = i_nxt_port;
                        n_tok.hit_port = 1'b1;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    // rule entries, no reset needed
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_port <= n_port;
    end

    // token stage, only the valid flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op       <= n_tok.op;
        r_tok.addr     <= n_tok.addr;
        r_tok.proto    <= n_tok.proto;
        r_tok.port     <= n_tok.port;
        r_tok.full     <= n_tok.full;
        r_tok.c_addr   <= n_tok.c_addr;
        r_tok.c_port   <= n_tok.c_port;
        r_tok.hit_addr <= n_tok.hit_addr;
        r_tok.hit_port <= n_tok.hit_port;
    end

    assign o_tok  = r_tok;
    assign o_addr = r_addr;
    assign o_port = r_port;

endmodule

@@ rtl/core/pacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pacl_ctrl
// Command control: launches a token into the cell chain, keeps the fill
// counts of both tables and turns the returning token into a result.
// ----------------------------------------------------------------------------
module pacl_ctrl
    import pacl_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    localparam int FW        = $clog2(RULE_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_pacl_in        i_cmd,
    input  t_pacl_tok       i_tail,
    output logic            o_busy,
    output t_pacl_tok       o_head,
    output logic [FW-1:0]   o_addr_fill,
    output logic [FW-1:0]   o_port_fill,
    output logic            o_valid,
    output t_pacl_out       o_res
);

    localparam logic [FW-1:0] FILL_MAX = FW'(RULE_DEPTH);

    logic            r_busy, n_busy;
    logic [FW-1:0]   r_addr_fill, n_addr_fill;
    logic [FW-1:0]   r_port_fill, n_port_fill;
    logic            r_valid, n_valid;
    t_pacl_out       r_res, n_res;
    logic            w_l4;

    // token launched on a transfer
    always_comb begin
        o_head          = '0;
        o_head.valid    = i_start && !r_busy;
        o_head.op       = i_cmd.op;
        o_head.addr     = i_cmd.address;
        o_head.proto    = i_cmd.protocol;
        o_head.port     = i_cmd.port;
        o_head.c_addr   = i_cmd.address;
        o_head.c_port   = i_cmd.port;
        o_head.full     = ((t_pacl_op'(i_cmd.op) == OP_ADD_ADDR) && (r_addr_fill == FILL_MAX))
                       || ((t_pacl_op'(i_cmd.op) == OP_ADD_PORT) && (r_port_fill == FILL_MAX));
    end

    assign w_l4 = (i_tail.proto == PROTO_TCP) || (i_tail.proto == PROTO_UDP);

    // result and fill update when the token leaves the last cell
    always_comb begin
        n_busy      = r_busy;
        n_addr_fill = r_addr_fill;
        n_port_fill = r_port_fill;
        n_valid     = 1'b0;
        n_res       = '0;
        if (o_head.valid) begin
            n_busy = 1'b1;
        end
        if (i_tail.valid) begin
            n_busy  = 1'b0;
            n_valid = 1'b1;
            unique case (t_pacl_op'(i_tail.op))
                OP_CHECK: begin
                    if (i_tail.hit_addr) begin
                        n_res.drop       = 1'b1;
                        n_res.drop_cause = CAUSE_ADDR;
                    end else if (i_tail.hit_port && w_l4) begin
                        n_res.drop       = 1'b1;
                        n_res.drop_cause = (i_tail.proto == PROTO_TCP) ? CAUSE_TCP
                                                                        : CAUSE_UDP;
                    end
                end
                OP_ADD_ADDR: begin
                    if (i_tail.full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_addr_fill = r_addr_fill + 1'b1;
                    end
                end
                OP_ADD_PORT: begin
                    if (i_tail.full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_port_fill = r_port_fill + 1'b1;
                    end
                end
                OP_DEL_ADDR: begin
                    if (i_tail.hit_addr) begin
                        n_addr_fill = r_addr_fill - 1'b1;
                    end else begin
                        n_res.status = ST_MISS;
                    end
                end
                OP_DEL_PORT: begin
                    if (i_tail.hit_port) begin
                        n_port_fill = r_port_fill - 1'b1;
                    end else begin
                        n_res.status = ST_MISS;
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_addr_fill <= '0;
            r_port_fill <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_addr_fill <= n_addr_fill;
            r_port_fill <= n_port_fill;
            r_valid     <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_busy      = r_busy;
    assign o_addr_fill = r_addr_fill;
    assign o_port_fill = r_port_fill;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/core/packet_acl_filter_core.sv @@
// ----------------------------------------------------------------------------
// packet_acl_filter_core
// Destination address and port access control list. A chain of rule cells
// holds both tables; each command walks the chain as a token, one cell per
// cycle, and returns one result.
//
//  channel   ports                     direction  transfer
//  command   start, busy, i_cmd        in         start high while busy low
//  result    o_valid, o_res            out        o_valid high, one cycle
//
//  From its transfer to its result strobe, a command's token passes every
//  cell of the chain, one cell a cycle, and then the result register.
//  busy is high while the token is in flight and drops in the strobe cycle,
//  so the next command can be taken then. Reset empties both tables by
//  clearing the fill counts; rule entries keep no reset value.
//  The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module packet_acl_filter_core
    import pacl_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF,
    localparam int FW        = $clog2(RULE_DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_pacl_in  i_cmd,
    output logic      o_valid,
    output t_pacl_out o_res
);

    t_pacl_tok     w_tok  [RULE_DEPTH+1];
    logic [31:0]   w_addr [RULE_DEPTH];
    logic [15:0]   w_port [RULE_DEPTH];
    logic [FW-1:0] w_addr_fill;
    logic [FW-1:0] w_port_fill;

    // command control and fill counts
    pacl_ctrl #(
        .RULE_DEPTH (RULE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_tail      (w_tok[RULE_DEPTH]),
        .o_busy      (busy),
        .o_head      (w_tok[0]),
        .o_addr_fill (w_addr_fill),
        .o_port_fill (w_port_fill),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

    // rule cell chain
    for (genvar g = 0; g < RULE_DEPTH; g++) begin : g_cell
        logic [31:0] w_nxt_addr;
        logic [15:0] w_nxt_port;

        // neighbour entry for delete, the last cell takes zero
        if (g < RULE_DEPTH - 1) begin : g_mid
            assign w_nxt_addr = w_addr[g+1];
            assign w_nxt_port = w_port[g+1];
        end else begin : g_last
            assign w_nxt_addr = '0;
            assign w_nxt_port = '0;
        end

        pacl_cell #(
            .RULE_DEPTH (RULE_DEPTH),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[g]),
            .i_addr_fill (w_addr_fill),
            .i_port_fill (w_port_fill),
            .i_nxt_addr  (w_nxt_addr),
            .i_nxt_port  (w_nxt_port),
            .o_tok       (w_tok[g+1]),
            .o_addr      (w_addr[g]),
            .o_port      (w_port[g])
        );
    end

endmodule

@@ test/pacl_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pacl_checker
// Watches the command and result channels of the access control list filter.
// Keeps its own copy of both rule tables, works out the verdict of every
// command taken by the block and compares each result strobe, field by field,
// with the oldest verdict still owed.
// ----------------------------------------------------------------------------
module pacl_checker
    import pacl_pkg::*;
#(
    parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_pacl_in  i_cmd,
    input  logic      i_valid,
    input  t_pacl_out i_res,
    output int        o_errors,
    output int        o_pending
);

    // shadow copy of the rule tables
    logic [31:0] addr_rules [RULE_DEPTH];
    logic [15:0] port_rules [RULE_DEPTH];
    int          addr_fill;
    int          port_fill;

    t_pacl_out   owed_verdicts [$];
    int          mismatch_count = 0;
    int          owed_count     = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = owed_count;

    // first address rule equal to a, or -1
    function automatic int find_addr(input logic [31:0] a);
        for (int i = 0; i < addr_fill; i++) begin
            if (addr_rules[i] == a) return i;
        end
        return -1;
    endfunction

    // first port rule equal to p, or -1
    function automatic int find_port(input logic [15:0] p);
        for (int i = 0; i < port_fill; i++) begin
            if (port_rules[i] == p) return i;
        end
        return -1;
    endfunction

    // verdict of one command, updating the shadow tables
    function automatic t_pacl_out acl_verdict(input t_pacl_in c);
        t_pacl_out r;
        int        hit;
        r.drop       = 1'b0;
        r.drop_cause = CAUSE_NONE;
        r.status     = ST_DONE;
        case (c.op)
            OP_CHECK: begin
                if (find_addr(c.address) >= 0) begin
                    r.drop       = 1'b1;
                    r.drop_cause = CAUSE_ADDR;
                end else if ((c.protocol == PROTO_TCP || c.protocol == PROTO_UDP)
                             && find_port(c.port) >= 0) begin
                    r.drop       = 1'b1;
                    r.drop_cause = (c.protocol == PROTO_TCP) ? CAUSE_TCP : CAUSE_UDP;
                end
            end
            OP_ADD_ADDR: begin
                if (addr_fill < RULE_DEPTH) begin
                    addr_rules[addr_fill] = c.address;
                    addr_fill++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_ADD_PORT: begin
                if (port_fill < RULE_DEPTH) begin
                    port_rules[port_fill] = c.port;
                    port_fill++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_DEL_ADDR: begin
                hit = find_addr(c.address);
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    // last valid entry fills the hole
                    addr_fill--;
                    addr_rules[hit] = addr_rules[addr_fill];
                end
            end
            OP_DEL_PORT: begin
                hit = find_port(c.port);
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    port_fill--;
                    port_rules[hit] = port_rules[port_fill];
                end
            end
            default: ; // unused op codes leave everything alone
        endcase
        return r;
    endfunction

    task automatic flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t pacl_checker: %s", $realtime, msg);
    endtask

    // compare result strobes, then record any command transfer
    always @(posedge i_clk) begin : watch
        t_pacl_out want;
        if (!i_rst_n) begin
            addr_fill = 0;
            port_fill = 0;
            owed_verdicts.delete();
        end else begin
            if (i_valid) begin
                if (owed_verdicts.size() == 0) begin
                    flag($sformatf("result with none owed: drop %0d cause %0d status %0d",
                                   i_res.drop, i_res.drop_cause, i_res.status));
                end else begin
                    want = owed_verdicts.pop_front();
                    if (i_res.drop !== want.drop)
                        flag($sformatf("drop: expected %0d, got %0d",
                                       want.drop, i_res.drop));
                    if (i_res.drop_cause !== want.drop_cause)
                        flag($sformatf("drop_cause: expected %0d, got %0d",
                                       want.drop_cause, i_res.drop_cause));
                    if (i_res.status !== want.status)
                        flag($sformatf("status: expected %0d, got %0d",
                                       want.status, i_res.status));
                end
            end
            if (i_start && !i_busy) owed_verdicts.push_back(acl_verdict(i_cmd));
        end
        owed_count = owed_verdicts.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for packet_acl_filter_core. A short directed run
// covers empty tables, duplicates, the protocol cases, unused op codes and
// deletes that miss; then chunks of random commands grow, mix and shrink the
// tables, filling each to the brim, under several sender idling patterns.
// Checking is done by pacl_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import pacl_pkg::*;

    localparam int RULE_DEPTH = RULE_DEPTH_DEF;
    localparam int CHUNK_LEN  = 105;

    // op codes the block does not use
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef enum int { GROW_ADDR, GROW_PORT, MIXED, SHRINK } t_mix;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_pacl_in  cmd;
    logic      o_valid;
    t_pacl_out res;
    int        errors;
    int        pending;

    int          idle_pct;
    logic [31:0] addr_pool [16];
    logic [15:0] port_pool [16];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    packet_acl_filter_core #(.RULE_DEPTH(RULE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd),
        .o_valid (o_valid),
        .o_res   (res)
    );

    pacl_checker #(.RULE_DEPTH(RULE_DEPTH)) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (cmd),
        .i_valid   (o_valid),
        .i_res     (res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    function automatic t_pacl_in make_cmd(input logic [2:0] op, input logic [31:0] a,
                                          input logic [7:0] proto, input logic [15:0] p);
        t_pacl_in c;
        c.op       = op;
        c.address  = a;
        c.protocol = proto;
        c.port     = p;
        return c;
    endfunction

    // random command; values mostly from small pools so rules get hit
    function automatic t_pacl_in rand_cmd(input t_mix mix);
        t_pacl_in c;
        int       roll;
        int       pr;
        c.address = ($urandom_range(4) == 0) ? $urandom() : addr_pool[$urandom_range(15)];
        c.port    = ($urandom_range(4) == 0) ? 16'($urandom()) : port_pool[$urandom_range(15)];
        pr = $urandom_range(9);
        c.protocol = (pr < 4) ? PROTO_TCP : (pr < 7) ? PROTO_UDP : 8'($urandom());
        roll = $urandom_range(99);
        if (roll < 3) begin
            c.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end else begin
            case (mix)
                GROW_ADDR: c.op = (roll < 72) ? OP_ADD_ADDR : (roll < 78) ? OP_ADD_PORT :
                                  (roll < 95) ? OP_CHECK : (roll < 97) ? OP_DEL_ADDR :
                                  OP_DEL_PORT;
                GROW_PORT: c.op = (roll < 72) ? OP_ADD_PORT : (roll < 78) ? OP_ADD_ADDR :
                                  (roll < 95) ? OP_CHECK : (roll < 97) ? OP_DEL_PORT :
                                  OP_DEL_ADDR;
                MIXED:     c.op = (roll < 50) ? OP_CHECK : (roll < 62) ? OP_ADD_ADDR :
                                  (roll < 74) ? OP_ADD_PORT : (roll < 87) ? OP_DEL_ADDR :
                                  OP_DEL_PORT;
                default:   c.op = (roll < 32) ? OP_DEL_ADDR : (roll < 61) ? OP_DEL_PORT :
                                  (roll < 86) ? OP_CHECK : (roll < 93) ? OP_ADD_ADDR :
                                  OP_ADD_PORT;
            endcase
        end
        return c;
    endfunction

    // one command transfer; called and returns at a falling edge
    task automatic send(input t_pacl_in c);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            if ($urandom_range(7) == 0) begin
                gap = $urandom_range(RULE_DEPTH + 8, 1);
            end else begin
                gap = 1;
                while ($urandom_range(99) < idle_pct && gap < 20) gap++;
            end
        end
        repeat (gap) begin
            start <= 1'b0;
            cmd   <= t_pacl_in'({$urandom(), $urandom()});
            @(negedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off until every owed result has come back
    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stim
        int idle_by_phase [4];
        t_mix chunk_mix [8];
        idle_by_phase = '{0, 54, 0, 34};
        chunk_mix = '{GROW_ADDR, MIXED, GROW_PORT, MIXED, SHRINK, GROW_PORT, GROW_ADDR,
                      SHRINK};

        i_rst_n  = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        idle_pct = 0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++) begin
            addr_pool[i] = $urandom();
            port_pool[i] = 16'($urandom());
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty tables, duplicates, protocols, unused ops, deletes
        send(make_cmd(OP_CHECK,    32'h0000_0000, PROTO_TCP, 16'h0000));
        send(make_cmd(OP_DEL_ADDR, 32'h0000_0000, 8'h00,     16'h0000));
        send(make_cmd(OP_DEL_PORT, 32'hFFFF_FFFF, 8'hFF,     16'hFFFF));
        send(make_cmd(OP_ADD_ADDR, 32'hFFFF_FFFF, 8'h00,     16'h0000));
        send(make_cmd(OP_ADD_ADDR, 32'h0000_0000, 8'hFF,     16'hFFFF));
        send(make_cmd(OP_ADD_ADDR, 32'hFFFF_FFFF, 8'h00,     16'h0000));
        send(make_cmd(OP_ADD_PORT, 32'h0000_0000, 8'h00,     16'hFFFF));
        send(make_cmd(OP_ADD_PORT, 32'hFFFF_FFFF, 8'hFF,     16'h0000));
        send(make_cmd(OP_CHECK,    32'hFFFF_FFFF, 8'h00,     16'h1234));
        send(make_cmd(OP_CHECK,    32'h1234_5678, PROTO_TCP, 16'hFFFF));
        send(make_cmd(OP_CHECK,    32'h0000_0001, PROTO_UDP, 16'h0000));
        send(make_cmd(OP_CHECK,    32'h0000_0001, 8'hFF,     16'h0000));
        send(make_cmd(OP_CHECK,    32'h8000_0000, 8'd7,      16'hFFFF));
        send(make_cmd(OP_CHECK,    32'h0000_0000, PROTO_UDP, 16'hFFFF));
        for (logic [3:0] op = 4'(OP_SPARE_LO); op <= 4'(OP_SPARE_HI); op++)
            send(make_cmd(op[2:0], 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send(make_cmd(OP_DEL_ADDR, 32'hFFFF_FFFF, 8'h00,     16'h0000));
        send(make_cmd(OP_DEL_ADDR, 32'h0000_0000, 8'h00,     16'h0000));
        send(make_cmd(OP_DEL_ADDR, 32'hFFFF_FFFF, 8'h00,     16'h0000));
        send(make_cmd(OP_DEL_ADDR, 32'hFFFF_FFFF, 8'h00,     16'h0000));
        send(make_cmd(OP_DEL_PORT, 32'h0000_0000, 8'h00,     16'h0001));
        send(make_cmd(OP_DEL_PORT, 32'h0000_0000, 8'h00,     16'hFFFF));
        send(make_cmd(OP_CHECK,    32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF));

        // random chunks, idling pattern changes every two chunks
        for (int k = 0; k < 8; k++) begin
            drain();
            idle_pct = idle_by_phase[k / 2];
            for (int n = 0; n < CHUNK_LEN; n++) send(rand_cmd(chunk_mix[k]));
        end

        // wait out the tail, allowing for stray strobes
        drain();
        repeat (RULE_DEPTH + 8) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(5_000_000);
        $display("tb: done, errors");
        $finish;
    end

endmodule
